/* src/tsa_gcd_pkg.sv */
package tsa_gcd_pkg;

   // Default number of timer slots
   localparam int SLOT_COUNT_DEFAULT = 20;

   // Field widths
   localparam int INTERVAL_W = 16;
   localparam int SLOT_ID_W  = 5;
   localparam int STATUS_W   = 2;
   localparam int SHIFT_W    = 4;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STOP  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_GCD  = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

endpackage

/* src/timer_slot_allocator_gcd_tick_core.sv */
// A stop, a start that finds no free slot, or a start into a zero period
//   or with a zero interval gives its result word the cycle after acceptance.
// A start that folds into a nonzero period runs a binary GCD on one shared
//   compare/subtract/shift unit, one step per cycle.
// Throughput: one word at a time; the next word is taken the cycle after the result leaves.
// Reset (synchronous): all slots free, base period zero, no result pending.
module timer_slot_allocator_gcd_tick_core #(
   parameter int SLOT_COUNT = tsa_gcd_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [tsa_gcd_pkg::INTERVAL_W-1:0]   req_interval,
   input  logic [tsa_gcd_pkg::SLOT_ID_W-1:0]    req_slot_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tsa_gcd_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tsa_gcd_pkg::SLOT_ID_W-1:0]    rsp_slot_index,
   output logic [tsa_gcd_pkg::INTERVAL_W-1:0]   rsp_base_period,
   output logic                                 rsp_tick_enabled
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // State and working registers
   logic [1:0]                              state_ff, state_in;
   logic [SLOT_COUNT-1:0]                   busy_ff, busy_in;
   logic [tsa_gcd_pkg::INTERVAL_W-1:0]      period_ff, period_in;
   logic [tsa_gcd_pkg::INTERVAL_W-1:0]      op_a_ff, op_a_in;
   logic [tsa_gcd_pkg::INTERVAL_W-1:0]      op_b_ff, op_b_in;
   logic [tsa_gcd_pkg::SHIFT_W-1:0]         shift_ff, shift_in;
   logic [tsa_gcd_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic [tsa_gcd_pkg::SLOT_ID_W-1:0]       index_ff, index_in;

   logic                                    free_found;
   logic [IDX_W-1:0]                        free_idx;
   logic [SLOT_COUNT-1:0]                   stop_mask;
   logic                                    stop_valid;
   logic                                    accept;

   // Find the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int n = SLOT_COUNT - 1; n >= 0; n--) begin
         if (!busy_ff[n]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(n);
         end
      end
   end

   // Decode the slot named by a stop
   always_comb begin
      for (int n = 0; n < SLOT_COUNT; n++) begin
         stop_mask[n] = (32'(req_slot_id) == n);
      end
   end

   assign stop_valid = (32'(req_slot_id) < SLOT_COUNT);
   assign accept     = req_valid && !req_stall;

   // Sequencer and shared GCD step
   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      period_in = period_ff;
      op_a_in   = op_a_ff;
      op_b_in   = op_b_ff;
      shift_in  = shift_ff;
      status_in = status_ff;
      index_in  = index_ff;

      unique case (state_ff)
         tsa_gcd_pkg::S_IDLE: begin
            if (accept) begin
               status_in = tsa_gcd_pkg::ST_OK;
               index_in  = '0;
               state_in  = tsa_gcd_pkg::S_RESP;
               if (req_cmd == tsa_gcd_pkg::CMD_START) begin
                  if (!free_found) begin
                     status_in = tsa_gcd_pkg::ST_FULL;
                  end else begin
                     busy_in  = busy_ff | (SLOT_COUNT'(1) << free_idx);
                     index_in = tsa_gcd_pkg::SLOT_ID_W'(32'(free_idx));
                     if (period_ff == '0) begin
                        period_in = req_interval;
                     end else if (req_interval != '0) begin
                        op_a_in  = period_ff;
                        op_b_in  = req_interval;
                        shift_in = '0;
                        state_in = tsa_gcd_pkg::S_GCD;
                     end
                  end
               end else begin
                  if (!stop_valid) begin
                     status_in = tsa_gcd_pkg::ST_INVALID;
                  end else begin
                     busy_in = busy_ff & ~stop_mask;
                     if (busy_in == '0) begin
                        period_in = '0;
                     end
                  end
               end
            end
         end
         tsa_gcd_pkg::S_GCD: begin
            // One binary GCD step: finish when equal, strip twos, or subtract the smaller odd operand
            if (op_a_ff == op_b_ff) begin
               period_in = op_a_ff << shift_ff;
               state_in  = tsa_gcd_pkg::S_RESP;
            end else if (!op_a_ff[0] && !op_b_ff[0]) begin
               op_a_in  = op_a_ff >> 1;
               op_b_in  = op_b_ff >> 1;
               shift_in = shift_ff + 1'b1;
            end else if (!op_a_ff[0]) begin
               op_a_in = op_a_ff >> 1;
            end else if (!op_b_ff[0]) begin
               op_b_in = op_b_ff >> 1;
            end else if (op_a_ff > op_b_ff) begin
               op_a_in = op_a_ff - op_b_ff;
            end else begin
               op_b_in = op_b_ff - op_a_ff;
            end
         end
         tsa_gcd_pkg::S_RESP: begin
            if (!rsp_stall) begin
               state_in = tsa_gcd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tsa_gcd_pkg::S_IDLE;
         end
      endcase
   end

   // Update control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tsa_gcd_pkg::S_IDLE;
         busy_ff   <= '0;
         period_ff <= '0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         period_ff <= period_in;
      end
   end

   // Hold working operands and the result word
   always_ff @(posedge clock) begin
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
      shift_ff  <= shift_in;
      status_ff <= status_in;
      index_ff  <= index_in;
   end

   assign req_stall        = (state_ff != tsa_gcd_pkg::S_IDLE);
   assign rsp_valid        = (state_ff == tsa_gcd_pkg::S_RESP);
   assign rsp_status       = status_ff;
   assign rsp_slot_index   = index_ff;
   assign rsp_base_period  = period_ff;
   assign rsp_tick_enabled = |busy_ff;

endmodule
